/* sv/gra_pkg.sv */
package gra_pkg;

	localparam int DEF_MAX_SIZE = 32;

	localparam int COST_W  = 10;
	localparam int BEST_W  = 11;
	localparam int IDX_W   = 5;
	localparam int TOTAL_W = 15;
	localparam int SIZE_W  = 6;
	localparam int N_W     = 7;

	localparam logic [COST_W-1:0] COST_MAX  = 10'd1000;
	localparam logic [BEST_W-1:0] COST_NONE = 11'd1001;

	typedef struct packed {
		logic [IDX_W-1:0]   worker;
		logic [IDX_W-1:0]   order;
		logic [COST_W-1:0]  row_cost;
		logic [TOTAL_W-1:0] total_cost;
		logic               last;
	} gra_result_t;

endpackage

/* sv/greedy_row_assignment.sv */
// Greedy row assignment of a square cost matrix. Costs enter one per request in
// row-major order; start_req on an element begins a new matrix. For each row the
// block keeps the cheapest column that no earlier row has taken (ties go to the
// later column) and at the row's last element returns worker, order, row_cost,
// the running total_cost and last. Elements inside a row return nothing. One
// request is taken every clock unless req_stall is high: each element passes
// an input register, one compare-and-mask step against the row state, and an
// output register that holds the result of a row's last element. The user must
// write the matrix side via matrix_size_we/matrix_size_wdata only while the
// block is idle, not enforced by it; 0 is taken as 1, above MAX_SIZE as MAX_SIZE.
module greedy_row_assignment import gra_pkg::*; #(
	parameter int MAX_SIZE = DEF_MAX_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               matrix_size_we,
	input  logic [SIZE_W-1:0]  matrix_size_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [COST_W-1:0]  cost,
	input  logic               start_req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [IDX_W-1:0]   worker,
	output logic [IDX_W-1:0]   order,
	output logic [COST_W-1:0]  row_cost,
	output logic [TOTAL_W-1:0] total_cost,
	output logic               last
);

	logic [SIZE_W-1:0] matrix_size_q;
	logic [N_W-1:0]    size_n;

	logic              valid_s1;
	logic [COST_W-1:0] cost_s1;
	logic              start_s1;

	logic              out_free;
	logic              fire;
	logic              row_end;
	gra_result_t       result;
	gra_result_t       rsp_q;
	logic              rsp_valid_q;

	always_comb begin
		if (matrix_size_q == '0) begin
			size_n = N_W'(1);
		end else if (N_W'(matrix_size_q) > N_W'(MAX_SIZE)) begin
			size_n = N_W'(MAX_SIZE);
		end else begin
			size_n = N_W'(matrix_size_q);
		end
	end

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= SIZE_W'(1);
		end else if (matrix_size_we) begin
			matrix_size_q <= matrix_size_wdata;
		end
	end

	// hold the request while the output side is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			cost_s1  <= cost;
			start_s1 <= start_req;
		end
	end

	gra_row_unit #(
		.MAX_SIZE(MAX_SIZE)
	) u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.cost     (cost_s1),
		.start_req(start_s1),
		.size_n   (size_n),
		.row_end  (row_end),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire && row_end) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && row_end) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign worker     = rsp_q.worker;
	assign order      = rsp_q.order;
	assign row_cost   = rsp_q.row_cost;
	assign total_cost = rsp_q.total_cost;
	assign last       = rsp_q.last;

endmodule

/* sv/gra_row_unit.sv */
module gra_row_unit import gra_pkg::*; #(
	parameter int MAX_SIZE = DEF_MAX_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [COST_W-1:0] cost,
	input  logic              start_req,
	input  logic [N_W-1:0]    size_n,
	output logic              row_end,
	output gra_result_t       result
);

	localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

	logic [MAX_SIZE-1:0] used_mask_q;
	logic [BEST_W-1:0]   best_cost_q;
	logic [CW-1:0]       best_col_q;
	logic [CW-1:0]       col_q;
	logic [CW-1:0]       row_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [MAX_SIZE-1:0] cur_mask;
	logic [BEST_W-1:0]   cur_best_cost;
	logic [CW-1:0]       cur_best_col;
	logic [CW-1:0]       cur_col;
	logic [CW-1:0]       cur_row;
	logic [TOTAL_W-1:0]  cur_total;

	logic [COST_W-1:0]   cost_sat;
	logic                taken;
	logic                take_new;
	logic [BEST_W-1:0]   new_best_cost;
	logic [CW-1:0]       new_best_col;
	logic                found;
	logic [CW-1:0]       chosen;
	logic [COST_W-1:0]   chosen_cost;
	logic [TOTAL_W-1:0]  total_next;
	logic                is_last;
	logic [MAX_SIZE-1:0] chosen_bit;

	always_comb begin
		cur_mask      = start_req ? '0 : used_mask_q;
		cur_best_cost = start_req ? COST_NONE : best_cost_q;
		cur_best_col  = start_req ? '0 : best_col_q;
		cur_col       = start_req ? '0 : col_q;
		cur_row       = start_req ? '0 : row_q;
		cur_total     = start_req ? '0 : total_q;

		cost_sat = (cost > COST_MAX) ? COST_MAX : cost;
		taken    = cur_mask[cur_col];
		take_new = !taken && ({1'b0, cost_sat} <= cur_best_cost);

		new_best_cost = take_new ? {1'b0, cost_sat} : cur_best_cost;
		new_best_col  = take_new ? cur_col : cur_best_col;

		row_end     = (N_W'(cur_col) + N_W'(1)) >= size_n;
		found       = new_best_cost <= BEST_W'(COST_MAX);
		chosen      = found ? new_best_col : '0;
		chosen_cost = found ? new_best_cost[COST_W-1:0] : '0;
		total_next  = cur_total + TOTAL_W'(chosen_cost);
		is_last     = (N_W'(cur_row) + N_W'(1)) >= size_n;
		chosen_bit  = found ? (MAX_SIZE'(1) << chosen) : '0;

		result.worker     = IDX_W'(cur_row);
		result.order      = IDX_W'(chosen);
		result.row_cost   = chosen_cost;
		result.total_cost = total_next;
		result.last       = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_mask_q <= '0;
			best_cost_q <= COST_NONE;
			best_col_q  <= '0;
			col_q       <= '0;
			row_q       <= '0;
			total_q     <= '0;
		end else if (fire) begin
			if (!row_end) begin
				used_mask_q <= cur_mask;
				best_cost_q <= new_best_cost;
				best_col_q  <= new_best_col;
				col_q       <= cur_col + CW'(1);
				row_q       <= cur_row;
				total_q     <= cur_total;
			end else if (is_last) begin
				used_mask_q <= '0;
				best_cost_q <= COST_NONE;
				best_col_q  <= '0;
				col_q       <= '0;
				row_q       <= '0;
				total_q     <= '0;
			end else begin
				used_mask_q <= cur_mask | chosen_bit;
				best_cost_q <= COST_NONE;
				best_col_q  <= '0;
				col_q       <= '0;
				row_q       <= cur_row + CW'(1);
				total_q     <= total_next;
			end
		end
	end

endmodule

/* tb/greedy_row_assignment_test.sv */
module greedy_row_assignment_test import gra_pkg::*;;

	localparam int PERIOD          = 10;
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_REQUESTS = 900;
	localparam int PLAN_ROWS       = 24;

	typedef enum logic [1:0] {ROW_ITEM, ROW_ITEM_CHECKED, ROW_SIZE} plan_kind_t;

	typedef struct {
		plan_kind_t  kind;
		int          value;
		logic        start;
		gra_result_t want;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               matrix_size_we = 1'b0;
	logic [SIZE_W-1:0]  matrix_size_wdata = '0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [COST_W-1:0]  cost = '0;
	logic               start_req = 1'b0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [IDX_W-1:0]   worker;
	logic [IDX_W-1:0]   order;
	logic [COST_W-1:0]  row_cost;
	logic [TOTAL_W-1:0] total_cost;
	logic               last;

	logic [SIZE_W-1:0]  side_setting;
	logic [31:0]        taken_cols;
	logic [BEST_W-1:0]  row_best_cost;
	logic [IDX_W-1:0]   row_best_col;
	int                 col_pos;
	int                 row_pos;
	int                 cost_sum;
	gra_result_t        assignments_due[$];

	plan_row_t plan [PLAN_ROWS];
	int        error_count = 0;
	int        cycle_count = 0;
	int        stall_left = 0;
	bit        tx_idling = 1'b1;
	bit        rx_idling = 1'b1;

	greedy_row_assignment u_top (
		.clk,
		.arst_n,
		.matrix_size_we,
		.matrix_size_wdata,
		.req_valid,
		.req_stall,
		.cost,
		.start_req,
		.rsp_valid,
		.rsp_stall,
		.worker,
		.order,
		.row_cost,
		.total_cost,
		.last
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int clamp_side(input int v);
		if (v < 1) return 1;
		if (v > DEF_MAX_SIZE) return DEF_MAX_SIZE;
		return v;
	endfunction

	function automatic gra_result_t row_result(input int w, input int o, input int c,
			input int t, input bit l);
		gra_result_t r;
		r.worker     = w[IDX_W-1:0];
		r.order      = o[IDX_W-1:0];
		r.row_cost   = c[COST_W-1:0];
		r.total_cost = t[TOTAL_W-1:0];
		r.last       = l;
		return r;
	endfunction

	task automatic clear_matrix_state();
		taken_cols    = '0;
		cost_sum      = 0;
		row_pos       = 0;
		col_pos       = 0;
		row_best_cost = COST_NONE;
		row_best_col  = '0;
	endtask

	task automatic greedy_step(input logic [COST_W-1:0] c, input logic s,
			output bit produced, output gra_result_t res);
		logic [BEST_W-1:0] clipped;
		int                n;
		bit                found;
		bit                final_row;
		res      = '0;
		produced = 1'b0;
		n        = clamp_side(side_setting);
		if (s)
			clear_matrix_state();
		clipped = (c > COST_MAX) ? {1'b0, COST_MAX} : {1'b0, c};
		if (!taken_cols[col_pos] && clipped <= row_best_cost) begin
			row_best_cost = clipped;
			row_best_col  = col_pos[IDX_W-1:0];
		end
		if (col_pos + 1 < n) begin
			col_pos++;
			return;
		end
		found = row_best_cost <= {1'b0, COST_MAX};
		if (found) begin
			taken_cols[row_best_col] = 1'b1;
			cost_sum += row_best_cost;
		end
		final_row = row_pos + 1 >= n;
		res = row_result(row_pos, found ? row_best_col : 0, found ? row_best_cost : 0,
			cost_sum, final_row);
		produced = 1'b1;
		if (final_row) begin
			clear_matrix_state();
		end else begin
			row_pos++;
			col_pos       = 0;
			row_best_cost = COST_NONE;
			row_best_col  = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	task automatic wait_drained();
		while (assignments_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_request(input int c, input logic s, input bit typed,
			input gra_result_t want);
		int          gap;
		bit          produced;
		gra_result_t predicted;
		gap = tx_idling ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cost      <= c[COST_W-1:0];
		start_req <= s;
		do @(negedge clk); while (req_stall);
		greedy_step(c[COST_W-1:0], s, produced, predicted);
		if (typed)
			assignments_due.push_back(want);
		else if (produced)
			assignments_due.push_back(predicted);
		@(posedge clk);
	endtask

	task automatic write_side(input int v);
		req_valid <= 1'b0;
		wait_drained();
		matrix_size_we    <= 1'b1;
		matrix_size_wdata <= v[SIZE_W-1:0];
		@(posedge clk);
		matrix_size_we <= 1'b0;
		side_setting = v[SIZE_W-1:0];
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			rsp_stall <= 1'b0;
			if (rx_idling)
				stall_left <= pick_gap();
		end
	end

	always @(negedge clk) begin
		gra_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (assignments_due.size() == 0) begin
				report_mismatch("unrequested result, worker", worker, -1);
			end else begin
				want = assignments_due.pop_front();
				if (worker !== want.worker)
					report_mismatch("worker", worker, want.worker);
				if (order !== want.order)
					report_mismatch("order", order, want.order);
				if (row_cost !== want.row_cost)
					report_mismatch("row_cost", row_cost, want.row_cost);
				if (total_cost !== want.total_cost)
					report_mismatch("total_cost", total_cost, want.total_cost);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int   side;
		int   n;
		int   burst;
		int   sent;
		int   k;
		int   c;
		logic st;
		bit   fresh;

		side_setting = 1;
		clear_matrix_state();
		plan = '{
			'{ROW_ITEM_CHECKED, 0,    1'b0, row_result(0, 0, 0, 0, 1)},
			'{ROW_ITEM_CHECKED, 1023, 1'b1, row_result(0, 0, 1000, 1000, 1)},
			'{ROW_SIZE,         0,    1'b0, '0},
			'{ROW_ITEM_CHECKED, 7,    1'b0, row_result(0, 0, 7, 7, 1)},
			'{ROW_SIZE,         2,    1'b0, '0},
			'{ROW_ITEM,         5,    1'b1, '0},
			'{ROW_ITEM_CHECKED, 5,    1'b0, row_result(0, 1, 5, 5, 0)},
			'{ROW_ITEM,         3,    1'b0, '0},
			'{ROW_ITEM_CHECKED, 9,    1'b0, row_result(1, 0, 3, 8, 1)},
			'{ROW_ITEM,         4,    1'b0, '0},
			'{ROW_ITEM,         600,  1'b1, '0},
			'{ROW_ITEM_CHECKED, 1000, 1'b0, row_result(0, 0, 600, 600, 0)},
			'{ROW_SIZE,         1,    1'b0, '0},
			'{ROW_ITEM_CHECKED, 2,    1'b0, row_result(1, 0, 0, 600, 1)},
			'{ROW_SIZE,         3,    1'b0, '0},
			'{ROW_ITEM,         10,   1'b1, '0},
			'{ROW_ITEM,         20,   1'b0, '0},
			'{ROW_SIZE,         2,    1'b0, '0},
			'{ROW_ITEM_CHECKED, 0,    1'b0, row_result(0, 2, 0, 0, 0)},
			'{ROW_ITEM,         1000, 1'b0, '0},
			'{ROW_ITEM_CHECKED, 1000, 1'b0, row_result(1, 1, 1000, 1000, 1)},
			'{ROW_SIZE,         63,   1'b0, '0},
			'{ROW_ITEM,         512,  1'b1, '0},
			'{ROW_ITEM,         511,  1'b0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SIZE)
				write_side(plan[i].value);
			else
				push_request(plan[i].value, plan[i].start,
					plan[i].kind == ROW_ITEM_CHECKED, plan[i].want);
		end

		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			tx_idling = $urandom_range(0, 3) != 0;
			rx_idling = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 9))
				0: side = $urandom_range(0, 63);
				1: side = DEF_MAX_SIZE;
				default: side = $urandom_range(1, 6);
			endcase
			write_side(side);
			n = clamp_side(side);
			if (n > 8)
				burst = n * $urandom_range(1, 2);
			else
				burst = n * n * $urandom_range(1, 4);
			// cut some bursts short to leave a matrix open across a size change
			if ($urandom_range(0, 3) == 0)
				burst = $urandom_range(1, burst);
			fresh = 1'b1;
			for (k = 0; k < burst; k++) begin
				if (k % (n * n) == 0)
					fresh = $urandom_range(0, 7) != 0;
				st = (k % (n * n) == 0) ? fresh : 1'b0;
				if ($urandom_range(0, 39) == 0)
					st = ~st;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: c = $urandom_range(0, 1000);
					4, 5, 6: c = $urandom_range(0, 3);
					7: c = 1000;
					8: c = $urandom_range(1001, 1023);
					default: c = $urandom_range(0, 1023);
				endcase
				push_request(c, st, 1'b0, '0);
				sent++;
			end
		end

		req_valid <= 1'b0;
		wait_drained();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
sv/gra_pkg.sv
sv/gra_row_unit.sv
sv/greedy_row_assignment.sv
tb/greedy_row_assignment_test.sv
